FILE: rtl/mlfd_pkg.sv
// Package: constants and types shared by the magic/length frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package mlfd_pkg;
	localparam int HEADER_BYTES = 4;
	localparam logic [7:0] MAGIC_FIRST = 8'hAC;
	localparam logic [7:0] MAGIC_SECOND = 8'hBE;
	localparam logic [15:0] RESET_MAX_LEN = 16'd1024;
	localparam int FILL_W = $clog2(HEADER_BYTES);

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		HDR_START,
		HDR_DROP1,
		HDR_DROP2
	} hdr_action_t;

	typedef struct packed {
		hdr_action_t action;
		logic [15:0] length;
	} hdr_result_t;
endpackage
`default_nettype wire

FILE: rtl/magic_length_frame_deframer.sv
// Top level: magic/length frame deframer with stream ports and APB config.
//
// Takes one received byte per word on the slave stream and hunts for a four-byte
// header: 0xAC 0xBE then a little-endian 16-bit payload length. A header whose
// length is at most max_payload_len (APB address 0, reset 1024) opens a frame and
// the next length bytes leave on the master stream, tlast on the last one, with
// the declared length alongside. Header bytes, zero-length frames and bytes lost
// to resync produce no output word. One byte is taken every cycle; the single
// output register stalls input only while it holds a word the sink has not taken.
`timescale 1ns / 1ps
`default_nettype none
module magic_length_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	// master stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] payload_byte, [23:8] frame_length
	output logic             m_tlast,   // frame_end
	// APB config
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import mlfd_pkg::*;

	localparam logic REG_MAX_LEN = 1'b0;

	byte_t                   window_q [HEADER_BYTES-1];
	logic [FILL_W-1:0]       fill_q;
	logic                    in_payload_q;
	logic [15:0]             remaining_q;
	logic [15:0]             cur_len_q;
	logic [15:0]             max_len_q;

	logic                    m_valid_q;
	byte_t                   out_byte_q;
	logic                    out_last_q;
	logic [15:0]             out_len_q;

	logic                    s_accept;
	logic                    cfg_write;
	hdr_result_t             hdr;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_MAX_LEN) ? {16'd0, max_len_q} : 32'd0;

	assign s_tready = !m_valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata = {out_len_q, out_byte_q};
	assign m_tlast = out_last_q;

	mlfd_hdr_check u_hdr (
		.hdr0    (window_q[0]),
		.hdr1    (window_q[1]),
		.hdr2    (window_q[2]),
		.hdr3    (s_tdata),
		.max_len (max_len_q),
		.result  (hdr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= RESET_MAX_LEN;
		end else if (cfg_write && paddr[2] == REG_MAX_LEN) begin
			max_len_q <= pwdata[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HEADER_BYTES-1; i++) begin
				window_q[i] <= '0;
			end
			fill_q       <= '0;
			in_payload_q <= 1'b0;
			remaining_q  <= '0;
			cur_len_q    <= '0;
		end else if (s_accept) begin
			if (in_payload_q) begin
				remaining_q <= remaining_q - 16'd1;
				if (remaining_q == 16'd1) begin
					in_payload_q <= 1'b0;
				end
			end else if (fill_q != FILL_W'(HEADER_BYTES-1)) begin
				window_q[fill_q] <= s_tdata;
				fill_q <= fill_q + FILL_W'(1);
			end else begin
				unique case (hdr.action)
					HDR_START: begin
						fill_q    <= '0;
						cur_len_q <= hdr.length;
						if (hdr.length != 16'd0) begin
							in_payload_q <= 1'b1;
							remaining_q  <= hdr.length;
						end
						for (int i = 0; i < HEADER_BYTES-1; i++) begin
							window_q[i] <= '0;
						end
					end
					HDR_DROP1: begin
						window_q[0] <= window_q[1];
						window_q[1] <= window_q[2];
						window_q[2] <= s_tdata;
						fill_q <= FILL_W'(HEADER_BYTES-1);
					end
					HDR_DROP2: begin
						window_q[0] <= window_q[2];
						window_q[1] <= s_tdata;
						window_q[2] <= '0;
						fill_q <= FILL_W'(HEADER_BYTES-2);
					end
					default: begin
						fill_q <= '0;
					end
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_accept && in_payload_q) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept && in_payload_q) begin
			out_byte_q <= s_tdata;
			out_last_q <= (remaining_q == 16'd1);
			out_len_q  <= cur_len_q;
		end
	end

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q == (remaining_q != 16'd0))
		else $error("payload flag and remaining count disagree");

	a_no_fill_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> fill_q == '0)
		else $error("header window not empty during payload");

	a_payload_emits: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && in_payload_q |=> m_valid_q)
		else $error("payload word accepted but no output word");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && in_payload_q && remaining_q == 16'd1 |=> m_tlast && !in_payload_q)
		else $error("last payload word not marked");
endmodule
`default_nettype wire

FILE: rtl/mlfd_hdr_check.sv
// Header check: magic word, length limit and resync decision for a full window.
`timescale 1ns / 1ps
`default_nettype none
module mlfd_hdr_check (
	input  wire mlfd_pkg::byte_t       hdr0,
	input  wire mlfd_pkg::byte_t       hdr1,
	input  wire mlfd_pkg::byte_t       hdr2,
	input  wire mlfd_pkg::byte_t       hdr3,
	input  wire logic [15:0]           max_len,
	output mlfd_pkg::hdr_result_t      result
);
	import mlfd_pkg::*;

	logic        magic_ok;
	logic [15:0] len;

	assign magic_ok = (hdr0 == MAGIC_FIRST) && (hdr1 == MAGIC_SECOND);
	assign len = {hdr3, hdr2};

	always_comb begin
		result.length = len;
		if (magic_ok) begin
			result.action = (len > max_len) ? HDR_DROP1 : HDR_START;
		end else if (hdr1 == MAGIC_FIRST) begin
			result.action = HDR_DROP1;
		end else begin
			result.action = HDR_DROP2;
		end
	end
endmodule
`default_nettype wire
